>>> rtl/chb_pkg.sv
// Package for the conflict-history branching score table.
// Holds the beat types, operation and register codes, sizes and reset values.
// Used by the top level and the divider; depends on nothing.
package chb_pkg;

    // Table depth and the address width that follows from it.
    localparam int NUM_VARS = 4096;
    localparam int VAR_AW   = $clog2(NUM_VARS);

    // Field and datapath widths.
    localparam int SCORE_W = 16;
    localparam int STEP_W  = 32;
    localparam int STAMP_W = 48;
    localparam int AGE_W   = STAMP_W + 1;
    localparam int PROD_W  = STEP_W + SCORE_W + 2;

    // The divider produces one quotient bit per cycle.
    localparam int DIV_STEPS = SCORE_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_STEP_INITIAL   = 2'd0;
    localparam logic [1:0] REG_STEP_MINIMUM   = 2'd1;
    localparam logic [1:0] REG_STEP_DECREMENT = 2'd2;

    localparam logic [STEP_W-1:0] STEP_INITIAL_RST   = 32'd1717986918;
    localparam logic [STEP_W-1:0] STEP_MINIMUM_RST   = 32'd257698038;
    localparam logic [STEP_W-1:0] STEP_DECREMENT_RST = 32'd4295;

    typedef enum logic [1:0] {
        OP_BUMP  = 2'd0,
        OP_STAMP = 2'd1,
        OP_DECAY = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [11:0]        var_req;
        logic [15:0]        multiplier;
        logic [STAMP_W-1:0] conflict_number;
        logic               active;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [STEP_W-1:0]  step;
    } out_item_t;

    // Request to and response from the divider.
    typedef struct packed {
        logic               start;
        logic [SCORE_W-1:0] dividend;
        logic [AGE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/chb_score_bump_table.sv
// Top level of the conflict-history branching score table: sequencer,
// configuration registers, step size and the two tables.
// Uses chb_pkg, chb_ram and chb_div_unit.
//
//  Channel   Signals                                    Direction
//  -------   ----------------------------------------   ---------
//  req       req_valid, req_stall, req_data (in_item)   in
//  rsp       rsp_valid, rsp_stall, rsp_data (out_item)  out
//  apb       psel, penable, pwrite, paddr, pwdata,      in/out
//            prdata, pready
//
// A bump passes from acceptance through the table read, the divider (its 16
// quotient bits, then its done flag), the multiply and the write-back. An age
// of 2^16 or more gives a zero reward without running the divider and so
// shortens a bump. Stamp, decay and no-op items go from the table read to write-back.
// After reset a clearing pass writes zero to all 4096 entries of both tables,
// one entry a cycle, during which no request beat is accepted.
// The result beat sits in an output register; a stalled result delays only
// the write-back of the next item.
module chb_score_bump_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  chb_pkg::in_item_t            req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output chb_pkg::out_item_t           rsp_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [chb_pkg::APB_AW-1:0]   paddr,
    input  logic [chb_pkg::APB_DW-1:0]   pwdata,
    output logic [chb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

    localparam logic [chb_pkg::VAR_AW-1:0] CLR_LAST =
        chb_pkg::VAR_AW'(chb_pkg::NUM_VARS - 1);

    state_t                          state_reg, state_next;
    logic [chb_pkg::VAR_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    chb_pkg::out_item_t              rsp_data_reg, rsp_data_next;
    chb_pkg::in_item_t               item_reg;
    logic [chb_pkg::SCORE_W-1:0]     reward_reg, reward_next;
    logic signed [chb_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic [chb_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [chb_pkg::STEP_W-1:0]      init_reg, init_next;
    logic [chb_pkg::STEP_W-1:0]      min_reg, min_next;
    logic [chb_pkg::STEP_W-1:0]      dec_reg, dec_next;

    logic                            req_acc;
    logic                            cfg_wr;
    logic [1:0]                      cfg_idx;
    logic [31:0]                     req_var_ext;
    logic [31:0]                     item_var_ext;
    logic [chb_pkg::VAR_AW-1:0]      rd_addr;
    logic [chb_pkg::VAR_AW-1:0]      item_addr;
    logic                            item_ok;
    logic                            bump_ok;
    logic                            fin_fire;

    logic [chb_pkg::SCORE_W-1:0]     score_rdata;
    logic [chb_pkg::STAMP_W-1:0]     stamp_rdata;
    logic                            score_we, stamp_we;
    logic [chb_pkg::VAR_AW-1:0]      wr_addr;
    logic [chb_pkg::SCORE_W-1:0]     score_wdata;
    logic [chb_pkg::STAMP_W-1:0]     stamp_wdata;

    logic [chb_pkg::AGE_W-1:0]       age_raw, age;
    logic                            stamp_future;
    chb_pkg::div_req_t               div_req;
    chb_pkg::div_rsp_t               div_rsp;

    logic signed [chb_pkg::SCORE_W:0]  blend_diff;
    logic signed [chb_pkg::PROD_W-1:0] blend_acc;
    logic [chb_pkg::SCORE_W-1:0]       blended_score;
    logic [chb_pkg::SCORE_W-1:0]       fin_score;
    logic [chb_pkg::STEP_W-1:0]        step_decayed;
    logic [chb_pkg::STEP_W-1:0]        fin_step;

    // Handshakes.
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];
    assign pready    = 1'b1;

    // Table addresses and the range check.
    assign req_var_ext  = 32'(req_data.var_req);
    assign item_var_ext = 32'(item_reg.var_req);
    assign rd_addr      = req_var_ext[chb_pkg::VAR_AW-1:0];
    assign item_addr    = item_var_ext[chb_pkg::VAR_AW-1:0];
    assign item_ok      = (item_var_ext < 32'(chb_pkg::NUM_VARS));
    assign bump_ok      = item_ok && (item_reg.op == chb_pkg::OP_BUMP);

    // Age of the last conflict, at least one, and one when the stamp lies ahead.
    assign stamp_future = (stamp_rdata > item_reg.conflict_number);
    assign age_raw      = {1'b0, item_reg.conflict_number} - {1'b0, stamp_rdata}
                        + chb_pkg::AGE_W'(1);
    assign age          = stamp_future ? chb_pkg::AGE_W'(1) : age_raw;

    assign div_req.start    = (state_reg == S_LOOK) && bump_ok;
    assign div_req.dividend = item_reg.multiplier;
    assign div_req.divisor  = age;

    // Blend: old + step * (reward - old), scaled by 2^-32.
    assign blend_diff    = $signed({1'b0, reward_reg}) - $signed({1'b0, score_rdata});
    assign blend_acc     = $signed({2'b00, score_rdata, 32'd0}) + prod_reg;
    assign blended_score = blend_acc[chb_pkg::STEP_W+chb_pkg::SCORE_W-1:chb_pkg::STEP_W];

    // Step decay while the step is above the minimum, saturating at zero.
    always_comb
    begin
        step_decayed = step_reg;
        if (step_reg > min_reg)
        begin
            if (step_reg > dec_reg)
            begin
                step_decayed = step_reg - dec_reg;
            end
            else
            begin
                step_decayed = '0;
            end
        end
    end

    // Write-back values of the item in hand.
    assign fin_fire = (state_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall);
    assign fin_step = (item_reg.op == chb_pkg::OP_DECAY) ? step_decayed : step_reg;

    always_comb
    begin
        if (!item_ok)
        begin
            fin_score = '0;
        end
        else if (item_reg.op == chb_pkg::OP_BUMP)
        begin
            fin_score = blended_score;
        end
        else
        begin
            fin_score = score_rdata;
        end
    end

    // Table write ports: the clearing pass, then item write-back.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            score_we    = 1'b1;
            stamp_we    = 1'b1;
            wr_addr     = clr_cnt_reg;
            score_wdata = '0;
            stamp_wdata = '0;
        end
        else
        begin
            score_we    = fin_fire && bump_ok;
            stamp_we    = fin_fire && item_ok && item_reg.active
                        && (item_reg.op == chb_pkg::OP_STAMP);
            wr_addr     = item_addr;
            score_wdata = blended_score;
            stamp_wdata = item_reg.conflict_number;
        end
    end

    chb_ram #(
        .WIDTH (chb_pkg::SCORE_W),
        .DEPTH (chb_pkg::NUM_VARS)
    ) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (wr_addr),
        .wdata (score_wdata),
        .re    (req_acc),
        .raddr (rd_addr),
        .rdata (score_rdata)
    );

    chb_ram #(
        .WIDTH (chb_pkg::STAMP_W),
        .DEPTH (chb_pkg::NUM_VARS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_addr),
        .wdata (stamp_wdata),
        .re    (req_acc),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

    chb_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        reward_next    = reward_reg;
        prod_next      = prod_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = bump_ok ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    reward_next = div_rsp.quotient;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = $signed({1'b0, step_reg}) * blend_diff;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_data_next.score = fin_score;
                    rsp_data_next.step  = fin_step;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // Datapath registers of the item in hand.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            item_reg <= req_data;
        end
        reward_reg <= reward_next;
        prod_reg   <= prod_next;
    end

    // Configuration registers and the step size.
    always_comb
    begin
        init_next = init_reg;
        min_next  = min_reg;
        dec_next  = dec_reg;
        step_next = step_reg;
        if (fin_fire && (item_reg.op == chb_pkg::OP_DECAY))
        begin
            step_next = step_decayed;
        end
        if (cfg_wr)
        begin
            case (cfg_idx)
                chb_pkg::REG_STEP_INITIAL:
                begin
                    init_next = pwdata;
                    step_next = pwdata;
                end
                chb_pkg::REG_STEP_MINIMUM:
                begin
                    min_next = pwdata;
                end
                chb_pkg::REG_STEP_DECREMENT:
                begin
                    dec_next = pwdata;
                end
                default:
                begin
                    init_next = init_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= chb_pkg::STEP_INITIAL_RST;
            min_reg  <= chb_pkg::STEP_MINIMUM_RST;
            dec_reg  <= chb_pkg::STEP_DECREMENT_RST;
            step_reg <= chb_pkg::STEP_INITIAL_RST;
        end
        else
        begin
            init_reg <= init_next;
            min_reg  <= min_next;
            dec_reg  <= dec_next;
            step_reg <= step_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            chb_pkg::REG_STEP_INITIAL:   prdata = init_reg;
            chb_pkg::REG_STEP_MINIMUM:   prdata = min_reg;
            chb_pkg::REG_STEP_DECREMENT: prdata = dec_reg;
            default:                     prdata = '0;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // No request beat is taken while the tables are being cleared.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("request accepted during clearing pass");

    // The divider only answers while the sequencer waits for it.
    a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider result outside divide state");

    // Tables are written only by the clearing pass or at write-back.
    a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        (score_we || stamp_we) |-> (state_reg == S_FIN || state_reg == S_CLEAR))
        else $error("table written outside write-back");

    // The step size only rises through a write of the initial value.
    a_step_falls: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_wr && (cfg_idx == chb_pkg::REG_STEP_INITIAL))
        |=> (step_reg <= $past(step_reg)))
        else $error("step size rose without a configuration write");

endmodule

>>> rtl/chb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the score and stamp tables.
module chb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/chb_div_unit.sv
// Iterative restoring divider: a 16-bit dividend over a 49-bit divisor.
// One quotient bit per cycle through a shared compare-and-subtract; uses chb_pkg.
module chb_div_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  chb_pkg::div_req_t req,
    output chb_pkg::div_rsp_t rsp
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    dstate_t                        state_reg, state_next;
    logic [chb_pkg::SCORE_W-1:0]    rem_reg, rem_next;
    logic [chb_pkg::SCORE_W-1:0]    quo_reg, quo_next;
    logic [chb_pkg::SCORE_W-1:0]    dsr_reg, dsr_next;
    logic [chb_pkg::DIV_CW-1:0]     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [chb_pkg::SCORE_W:0]      trial;
    logic [chb_pkg::SCORE_W:0]      trial_diff;
    logic                           big_divisor;

    // A divisor of 2^16 or more always gives a zero quotient.
    assign big_divisor = (req.divisor[chb_pkg::AGE_W-1:chb_pkg::SCORE_W] != '0);

    // Shared compare and subtract for one quotient bit.
    assign trial      = {rem_reg, quo_reg[chb_pkg::SCORE_W-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    if (big_divisor)
                    begin
                        quo_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = req.dividend;
                        dsr_next   = req.divisor[chb_pkg::SCORE_W-1:0];
                        cnt_next   = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_next = trial_diff[chb_pkg::SCORE_W-1:0];
                    quo_next = {quo_reg[chb_pkg::SCORE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[chb_pkg::SCORE_W-1:0];
                    quo_next = {quo_reg[chb_pkg::SCORE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == chb_pkg::DIV_CW'(chb_pkg::DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dsr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            dsr_reg   <= dsr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
